/* sv/mtok_pkg.sv */
// Shared types, token kinds, scanner state codes and character constants of the tokenizer.
package mtok_pkg;

  localparam int MTOK_MAX_TOKEN_BYTES = 4096;
  localparam int LIMIT_W = 13;

  // register indexes
  localparam logic REG_TOKEN_LIMIT = 1'b0;
  localparam logic REG_KEEP_TEXT   = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd256;

  // token kinds
  localparam logic [3:0] K_CONTENT  = 4'd0;
  localparam logic [3:0] K_OPEN     = 4'd1;
  localparam logic [3:0] K_CLOSE    = 4'd2;
  localparam logic [3:0] K_ATTR     = 4'd3;
  localparam logic [3:0] K_VALUE    = 4'd4;
  localparam logic [3:0] K_CHILDREN = 4'd5;
  localparam logic [3:0] K_EMPTY    = 4'd6;
  localparam logic [3:0] K_EOF      = 4'd7;
  localparam logic [3:0] K_ERROR    = 4'd8;

  // scanner states
  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_CONTENT    = 4'd1;
  localparam logic [3:0] ST_LT         = 4'd2;
  localparam logic [3:0] ST_BANG       = 4'd3;
  localparam logic [3:0] ST_BANG_DASH  = 4'd4;
  localparam logic [3:0] ST_COMMENT    = 4'd5;
  localparam logic [3:0] ST_SKIP_GT    = 4'd6;
  localparam logic [3:0] ST_PI         = 4'd7;
  localparam logic [3:0] ST_CLOSE_NAME = 4'd8;
  localparam logic [3:0] ST_CLOSE_TAIL = 4'd9;
  localparam logic [3:0] ST_OPEN       = 4'd10;
  localparam logic [3:0] ST_SLASH      = 4'd11;
  localparam logic [3:0] ST_EQ         = 4'd12;
  localparam logic [3:0] ST_QVAL       = 4'd13;
  localparam logic [3:0] ST_BARE       = 4'd14;
  localparam logic [3:0] ST_ATTR       = 4'd15;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QM    = 8'h3f;

  localparam logic [15:0] WINDOW_RESET = 16'h2323;
  localparam logic [15:0] WINDOW_DASHES = 16'h2d2d;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       at_end;
    logic       want_content;
  } in_word_t;

  typedef struct packed {
    logic       is_token_end;
    logic [7:0] text_byte;
    logic [3:0] kind;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] token_limit;
    logic               keep_content_text;
  } cfg_t;

endpackage

/* sv/markup_tokenizer_top.sv */
// Top level of the markup tokenizer: configuration registers, scanner and result queue.
//
// One input byte (or end mark) is taken per clock cycle. Its zero, one or two result
// words are computed in the same cycle from the scanner state and land in a three-entry result
// queue; with the queue empty the first of them appears on the output in the next cycle. An
// input word is taken while at most one result word remains queued after the current output
// draw, so once two words are queued the input holds for as long as the sink stalls. There
// is no clearing pass after reset.
module markup_tokenizer_top #(
  parameter int MAX_TOKEN_BYTES = mtok_pkg::MTOK_MAX_TOKEN_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  mtok_pkg::in_word_t  byte_word,
  output logic                tok_valid,
  input  logic                tok_stall,
  output mtok_pkg::out_word_t tok_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  mtok_pkg::cfg_t      cfg;
  mtok_pkg::out_word_t res0;
  mtok_pkg::out_word_t res1;
  logic [1:0]          nres;
  logic                accept;
  logic                pop;
  logic [1:0]          push;
  mtok_pkg::out_word_t queue [3];
  logic [1:0]          rptr;
  logic [1:0]          wptr;
  logic [1:0]          count;
  logic [1:0]          count_next;
  logic [1:0]          wptr_plus;
  logic                reg_sel;

  function automatic logic [1:0] inc3(logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.token_limit       <= mtok_pkg::LIMIT_RESET;
      cfg.keep_content_text <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        mtok_pkg::REG_TOKEN_LIMIT: cfg.token_limit       <= pwdata[mtok_pkg::LIMIT_W-1:0];
        mtok_pkg::REG_KEEP_TEXT:   cfg.keep_content_text <= pwdata[0];
        default: cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mtok_pkg::REG_TOKEN_LIMIT: prdata = {{(32 - mtok_pkg::LIMIT_W){1'b0}}, cfg.token_limit};
      mtok_pkg::REG_KEEP_TEXT:   prdata = {31'd0, cfg.keep_content_text};
      default:                   prdata = 32'd0;
    endcase
  end

  // handshake: room for two words after this cycle's draw
  assign pop        = tok_valid && !tok_stall;
  assign byte_stall = (count == 2'd3) || (count == 2'd2 && !pop);
  assign accept     = byte_valid && !byte_stall;
  assign push       = accept ? nres : 2'd0;

  mtok_scan #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .in_word (byte_word),
    .cfg     (cfg),
    .res0    (res0),
    .res1    (res1),
    .nres    (nres)
  );

  // result queue
  assign wptr_plus  = inc3(wptr);
  assign count_next = count - {1'b0, pop} + push;
  assign tok_valid  = (count != 2'd0);
  assign tok_word   = queue[rptr];

  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      queue[wptr] <= res0;
    end
    if (push == 2'd2) begin
      queue[wptr_plus] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= 2'd0;
      wptr  <= 2'd0;
      count <= 2'd0;
    end else begin
      count <= count_next;
      if (pop) begin
        rptr <= inc3(rptr);
      end
      if (push == 2'd1) begin
        wptr <= wptr_plus;
      end else if (push == 2'd2) begin
        wptr <= inc3(wptr_plus);
      end
    end
  end

  // a word that is not the last of its byte is always followed by another
  a_second_word: assert property (@(posedge clk) disable iff (rst)
    pop && !tok_word.last |=> tok_valid)
    else $error("second result word of a byte missing");

  // results of an accepted byte show up in the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push != 2'd0 |=> tok_valid)
    else $error("pushed result not presented");

  // the input is taken only with room for two words
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    accept |-> (count - {1'b0, pop}) <= 2'd1)
    else $error("result queue could overflow");

  // the queue count follows pushes and draws
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !accept && !pop |=> count == $past(count))
    else $error("queue count changed without traffic");

endmodule

/* sv/mtok_scan.sv */
// Tokenizer scanner: state registers and the per-byte state update, with the reprocess pass.
module mtok_scan #(
  parameter int MAX_TOKEN_BYTES = mtok_pkg::MTOK_MAX_TOKEN_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  mtok_pkg::in_word_t  in_word,
  input  mtok_pkg::cfg_t      cfg,
  output mtok_pkg::out_word_t res0,
  output mtok_pkg::out_word_t res1,
  output logic [1:0]          nres
);

  localparam int CNT_W = (MAX_TOKEN_BYTES > 2) ? $clog2(MAX_TOKEN_BYTES) : 1;
  localparam int LIM_W = ($clog2(MAX_TOKEN_BYTES + 1) > mtok_pkg::LIMIT_W) ?
                         $clog2(MAX_TOKEN_BYTES + 1) : mtok_pkg::LIMIT_W;
  localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MAX_TOKEN_BYTES);
  localparam logic [LIM_W-1:0] LIM_MIN = LIM_W'(2);

  typedef struct packed {
    logic [3:0]       st;
    logic [CNT_W-1:0] cnt;
    logic [15:0]      win;
    logic             prev_q;
    logic             quote_dbl;
  } scan_t;

  typedef struct packed {
    scan_t               s;
    mtok_pkg::out_word_t r0;
    mtok_pkg::out_word_t r1;
    logic [1:0]          n;
    logic                redo;
  } step_t;

  scan_t      state;
  scan_t      state_next;
  step_t      first;
  step_t      second;
  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] tl_ext;

  function automatic step_t put(step_t r, logic mark, logic [7:0] b, logic [3:0] k);
    mtok_pkg::out_word_t w;
    w.is_token_end = mark;
    w.text_byte    = b;
    w.kind         = k;
    w.last         = 1'b0;
    if (r.n == 2'd0) begin
      r.r0 = w;
    end else begin
      r.r1 = w;
    end
    r.n = r.n + 2'd1;
    return r;
  endfunction

  function automatic step_t fin(step_t r, logic [3:0] k);
    r = put(r, 1'b1, 8'h00, k);
    r.s.st  = mtok_pkg::ST_IDLE;
    r.s.cnt = '0;
    return r;
  endfunction

  function automatic step_t txt(step_t r, logic [7:0] b, logic [LIM_W-1:0] l);
    logic [LIM_W-1:0] nxt;
    r = put(r, 1'b0, b, mtok_pkg::K_CONTENT);
    nxt = LIM_W'(r.s.cnt) + LIM_W'(1);
    if (nxt >= l) begin
      r = fin(r, mtok_pkg::K_ERROR);
    end else begin
      r.s.cnt = nxt[CNT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic is_delim(logic [7:0] b);
    return (b <= mtok_pkg::CH_SPACE) || (b == mtok_pkg::CH_LT) || (b == mtok_pkg::CH_EQ) ||
           (b == mtok_pkg::CH_GT) || (b == mtok_pkg::CH_SLASH) ||
           (b == mtok_pkg::CH_DQ) || (b == mtok_pkg::CH_SQ);
  endfunction

  function automatic step_t feed(scan_t s, logic [7:0] b, logic e, logic w, logic keep,
                                 logic [LIM_W-1:0] l);
    step_t      r;
    logic [3:0] k;
    r      = '0;
    r.s    = s;
    k      = mtok_pkg::K_VALUE;
    case (s.st)
      mtok_pkg::ST_CONTENT: begin
        if (e) begin
          r = fin(r, mtok_pkg::K_EOF);
        end else if (b == mtok_pkg::CH_LT) begin
          r = fin(r, mtok_pkg::K_CONTENT);
          r.s.st = mtok_pkg::ST_LT;
        end else if (keep) begin
          r = txt(r, b, l);
        end
      end
      mtok_pkg::ST_LT: begin
        if (e) begin
          r = fin(r, mtok_pkg::K_ERROR);
        end else if (b == mtok_pkg::CH_BANG) begin
          r.s.st = mtok_pkg::ST_BANG;
        end else if (b == mtok_pkg::CH_QM) begin
          r.s.st = mtok_pkg::ST_PI;
          r.s.prev_q = 1'b0;
        end else if (b == mtok_pkg::CH_SLASH) begin
          r.s.st = mtok_pkg::ST_CLOSE_NAME;
          r.s.cnt = '0;
        end else if (is_delim(b)) begin
          r = fin(r, mtok_pkg::K_OPEN);
          r.redo = 1'b1;
        end else begin
          r.s.st = mtok_pkg::ST_OPEN;
          r.s.cnt = '0;
          r = txt(r, b, l);
        end
      end
      mtok_pkg::ST_BANG, mtok_pkg::ST_BANG_DASH: begin
        if (e) begin
          r = fin(r, mtok_pkg::K_ERROR);
        end else if (b == mtok_pkg::CH_DASH) begin
          if (s.st == mtok_pkg::ST_BANG) begin
            r.s.st = mtok_pkg::ST_BANG_DASH;
          end else begin
            r.s.st = mtok_pkg::ST_COMMENT;
            r.s.win = mtok_pkg::WINDOW_RESET;
          end
        end else if (b == mtok_pkg::CH_GT) begin
          r.s.st = mtok_pkg::ST_IDLE;
        end else begin
          r.s.st = mtok_pkg::ST_SKIP_GT;
        end
      end
      mtok_pkg::ST_COMMENT: begin
        if (e) begin
          r = fin(r, mtok_pkg::K_ERROR);
        end else if (s.win == mtok_pkg::WINDOW_DASHES && b == mtok_pkg::CH_GT) begin
          r.s.st = mtok_pkg::ST_IDLE;
        end else begin
          r.s.win = {s.win[7:0], b};
        end
      end
      mtok_pkg::ST_SKIP_GT: begin
        if (e) begin
          r = fin(r, mtok_pkg::K_ERROR);
        end else if (b == mtok_pkg::CH_GT) begin
          r.s.st = mtok_pkg::ST_IDLE;
        end
      end
      mtok_pkg::ST_PI: begin
        if (e) begin
          r = fin(r, mtok_pkg::K_ERROR);
        end else if (s.prev_q && b == mtok_pkg::CH_GT) begin
          r.s.st = mtok_pkg::ST_IDLE;
          r.s.prev_q = 1'b0;
        end else begin
          r.s.prev_q = (b == mtok_pkg::CH_QM);
        end
      end
      mtok_pkg::ST_CLOSE_NAME, mtok_pkg::ST_CLOSE_TAIL: begin
        if (e) begin
          r = fin(r, mtok_pkg::K_ERROR);
        end else if (b <= mtok_pkg::CH_SPACE) begin
          r.s.st = mtok_pkg::ST_CLOSE_TAIL;
        end else if (b == mtok_pkg::CH_GT) begin
          r = fin(r, mtok_pkg::K_CLOSE);
        end else if (s.st == mtok_pkg::ST_CLOSE_TAIL || is_delim(b)) begin
          r = fin(r, mtok_pkg::K_ERROR);
        end else begin
          r = txt(r, b, l);
        end
      end
      mtok_pkg::ST_OPEN, mtok_pkg::ST_ATTR, mtok_pkg::ST_BARE: begin
        if (s.st == mtok_pkg::ST_OPEN) begin
          k = mtok_pkg::K_OPEN;
        end else if (s.st == mtok_pkg::ST_ATTR) begin
          k = mtok_pkg::K_ATTR;
        end
        if (e || is_delim(b)) begin
          r = fin(r, k);
          r.redo = 1'b1;
        end else begin
          r = txt(r, b, l);
        end
      end
      mtok_pkg::ST_SLASH: begin
        r = fin(r, (!e && b == mtok_pkg::CH_GT) ? mtok_pkg::K_EMPTY : mtok_pkg::K_ERROR);
      end
      mtok_pkg::ST_EQ: begin
        if (e) begin
          r = fin(r, mtok_pkg::K_VALUE);
          r.redo = 1'b1;
        end else if (b <= mtok_pkg::CH_SPACE) begin
          r.s = s;
        end else if (b == mtok_pkg::CH_DQ || b == mtok_pkg::CH_SQ) begin
          r.s.st = mtok_pkg::ST_QVAL;
          r.s.quote_dbl = (b == mtok_pkg::CH_DQ);
          r.s.cnt = '0;
        end else if (is_delim(b)) begin
          r = fin(r, mtok_pkg::K_VALUE);
          r.redo = 1'b1;
        end else begin
          r.s.st = mtok_pkg::ST_BARE;
          r.s.cnt = '0;
          r = txt(r, b, l);
        end
      end
      mtok_pkg::ST_QVAL: begin
        if (e) begin
          r = fin(r, mtok_pkg::K_VALUE);
          r.redo = 1'b1;
        end else if (b == (s.quote_dbl ? mtok_pkg::CH_DQ : mtok_pkg::CH_SQ)) begin
          r = fin(r, mtok_pkg::K_VALUE);
        end else begin
          r = txt(r, b, l);
        end
      end
      default: begin
        // between tokens
        r.s.st  = mtok_pkg::ST_IDLE;
        r.s.cnt = '0;
        if (e) begin
          r = fin(r, mtok_pkg::K_EOF);
        end else if (w) begin
          if (b == mtok_pkg::CH_LT) begin
            r = fin(r, mtok_pkg::K_CONTENT);
            r.s.st = mtok_pkg::ST_LT;
          end else begin
            r.s.st = mtok_pkg::ST_CONTENT;
            if (keep) begin
              r = txt(r, b, l);
            end
          end
        end else if (b <= mtok_pkg::CH_SPACE) begin
          r.s.st = mtok_pkg::ST_IDLE;
        end else if (b == mtok_pkg::CH_LT) begin
          r.s.st = mtok_pkg::ST_LT;
        end else if (b == mtok_pkg::CH_GT) begin
          r = fin(r, mtok_pkg::K_CHILDREN);
        end else if (b == mtok_pkg::CH_SLASH) begin
          r.s.st = mtok_pkg::ST_SLASH;
        end else if (b == mtok_pkg::CH_EQ) begin
          r.s.st = mtok_pkg::ST_EQ;
        end else if (b == mtok_pkg::CH_DQ || b == mtok_pkg::CH_SQ) begin
          r = fin(r, mtok_pkg::K_ERROR);
        end else begin
          r.s.st = mtok_pkg::ST_ATTR;
          r = txt(r, b, l);
        end
      end
    endcase
    return r;
  endfunction

  // clamp the limit into the supported range
  always_comb begin
    tl_ext = LIM_W'(cfg.token_limit);
    if (tl_ext < LIM_MIN) begin
      lim = LIM_MIN;
    end else if (tl_ext > LIM_MAX) begin
      lim = LIM_MAX;
    end else begin
      lim = tl_ext;
    end
  end

  always_comb begin
    logic [2:0] total;
    first  = feed(state, in_word.in_byte, in_word.at_end, in_word.want_content,
                  cfg.keep_content_text, lim);
    second = feed(first.s, in_word.in_byte, in_word.at_end, in_word.want_content,
                  cfg.keep_content_text, lim);
    if (!first.redo) begin
      second.n = 2'd0;
      second.s = first.s;
    end
    state_next = second.s;
    total = {1'b0, first.n} + {1'b0, second.n};
    // keep the first two words; any further word is dropped
    nres = (total > 3'd2) ? 2'd2 : total[1:0];
    res0 = (first.n != 2'd0) ? first.r0 : second.r0;
    if (first.n == 2'd2) begin
      res1 = first.r1;
    end else if (first.n == 2'd1) begin
      res1 = second.r0;
    end else begin
      res1 = second.r1;
    end
    res0.last = (nres == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.st        <= mtok_pkg::ST_IDLE;
      state.cnt       <= '0;
      state.win       <= mtok_pkg::WINDOW_RESET;
      state.prev_q    <= 1'b0;
      state.quote_dbl <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule
